/* rtl/nirtc_pkg.sv */
// ----------------------------------------------------------------------------
// nirtc_pkg
// Shared types, codes and helper functions of the nibble-indexed RTC device.
// ----------------------------------------------------------------------------
package nirtc_pkg;

    // Request kinds carried in s_tuser.
    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    // Bus offset of the nibble-serial window.
    localparam logic [3:0] WINDOW_OFFSET = 4'd10;

    // Window phase codes.
    localparam logic [1:0] PHASE_INDEX = 2'd0;
    localparam logic [1:0] PHASE_HIGH  = 2'd1;
    localparam logic [1:0] PHASE_LOW   = 2'd2;

    // Clock store entries that the tick logic walks through, in carry order.
    localparam logic [2:0] FIELD_SECONDS = 3'd0;
    localparam logic [2:0] FIELD_MINUTES = 3'd1;
    localparam logic [2:0] FIELD_HOURS   = 3'd2;
    localparam logic [2:0] FIELD_DAYS    = 3'd3;
    localparam logic [2:0] FIELD_MONTHS  = 3'd4;
    localparam logic [2:0] FIELD_YEARS   = 3'd5;

    localparam logic [3:0] REG_MONTHS  = 4'd4;
    localparam logic [3:0] REG_YEARS   = 4'd5;
    localparam logic [3:0] REG_CONTROL = 4'd15;

    localparam logic [7:0] CLOCK_RESET_IMAGE [16] = '{
        8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h80, 8'h01, 8'h01,
        8'h00, 8'h0A, 8'h28, 8'h12, 8'h0A, 8'h4E, 8'h00, 8'h01
    };

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       capture;   // latch the accepted request
        logic       bus_exec;  // perform the bus access of the latched request
        logic       tick_en;   // advance one time field
        logic [2:0] field;     // time field that tick_en works on
        logic       out_load;  // move the result into the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_tick;       // latched request is a one-second tick
        logic tick_enabled;  // run bit of the control entry
        logic carry;         // current time field wrapped and carries on
    } status_t;

    // A byte read as two decimal digits; nibbles above nine count at face value.
    function automatic logic [7:0] bcd_decode(input logic [7:0] b);
        logic [7:0] hi;
        hi = {4'b0000, b[7:4]};
        return (hi << 3) + (hi << 1) + {4'b0000, b[3:0]};
    endfunction

    function automatic logic [7:0] days_in_month(input logic [7:0] month,
                                                 input logic       leap);
        logic [7:0] days;
        case (month)
            8'd2:                       days = leap ? 8'd29 : 8'd28;
            8'd4, 8'd6, 8'd9, 8'd11:    days = 8'd30;
            default:                    days = 8'd31;
        endcase
        return days;
    endfunction

endpackage

/* rtl/nibble_indexed_rtc_register_device.sv */
// ----------------------------------------------------------------------------
// nibble_indexed_rtc_register_device
// Bus register block with a nibble-serial BCD real-time clock store.
// ----------------------------------------------------------------------------
// Each request on the s_ channel is a bus write, a bus read or a one-second
// tick, selected by s_tuser; s_tdata carries the bus offset and write byte.
// Every request returns exactly one byte on the m_ channel: the read data
// for a read, zero otherwise.
// A bus request is accepted while the block is idle, executed in the next
// cycle, and its result is then loaded into the output register in the
// response state once that register is free, which raises m_tvalid. A tick
// with the run bit set walks the seconds, minutes, hours, day, month and
// year fields through one shared BCD incrementer, one field per cycle until
// the carry stops or the year field is reached.
// The output register holds its result while m_tready is low; a finished
// result waits there, and the block accepts no new request until it has
// been able to load the result of the current one.
// Reset (aresetn low at a clock edge) clears the byte registers and the
// window pointer and loads the clock store with its default image at once.
// ----------------------------------------------------------------------------
module nibble_indexed_rtc_register_device (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [3:0] offset, [11:4] write_data
    input  logic [1:0]  s_tuser,   // [1:0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [7:0] read_data
);

    nirtc_pkg::cmd_t    cmd;
    nirtc_pkg::status_t status;

    nirtc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    nirtc_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_tuser (s_tuser),
        .s_tdata (s_tdata),
        .status  (status),
        .m_tdata (m_tdata)
    );

endmodule

/* rtl/nirtc_ctrl.sv */
// ----------------------------------------------------------------------------
// nirtc_ctrl
// Sequencer: accepts a request, runs the bus access or the tick carry chain
// one field per cycle, and hands the result to the output register.
// ----------------------------------------------------------------------------
module nirtc_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  nirtc_pkg::status_t status,
    output nirtc_pkg::cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_TICK,
        ST_RESP
    } state_t;

    state_t     state_reg;
    logic [2:0] field_reg;
    logic       m_tvalid_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        cmd          = '0;
        cmd.field    = nirtc_pkg::FIELD_SECONDS;
        case (state_reg)
            ST_IDLE: begin
                cmd.capture = s_tvalid;
            end
            ST_EXEC: begin
                cmd.bus_exec = 1'b1;
            end
            ST_TICK: begin
                cmd.tick_en = 1'b1;
                cmd.field   = field_reg;
            end
            ST_RESP: begin
                cmd.out_load = !m_tvalid_reg || m_tready;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            field_reg    <= nirtc_pkg::FIELD_SECONDS;
            m_tvalid_reg <= 1'b0;
        end else begin
            // A new result may replace the one leaving in the same cycle.
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (status.is_tick && status.tick_enabled) begin
                        state_reg <= ST_TICK;
                        field_reg <= nirtc_pkg::FIELD_SECONDS;
                    end else begin
                        state_reg <= ST_RESP;
                    end
                end
                ST_TICK: begin
                    // The chain stops at the first field that does not wrap.
                    if (status.carry && field_reg != nirtc_pkg::FIELD_YEARS) begin
                        field_reg <= field_reg + 3'd1;
                    end else begin
                        state_reg <= ST_RESP;
                    end
                end
                ST_RESP: begin
                    if (cmd.out_load) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/nirtc_datapath.sv */
// ----------------------------------------------------------------------------
// nirtc_datapath
// Byte registers, clock store, window pointer, BCD incrementer and the
// result and output registers.
// ----------------------------------------------------------------------------
module nirtc_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  nirtc_pkg::cmd_t    cmd,
    input  logic [1:0]         s_tuser,  // [1:0] mode
    input  logic [15:0]        s_tdata,  // [3:0] offset, [11:4] write_data
    output nirtc_pkg::status_t status,
    output logic [7:0]         m_tdata   // [7:0] read_data
);

    logic [1:0] mode_reg;
    logic [3:0] offset_reg;
    logic [7:0] wdata_reg;
    logic [7:0] result_reg;
    logic [7:0] m_data_reg;

    logic [7:0] control_bytes_reg [8];
    logic [7:0] clock_store_reg [16];
    logic [1:0] phase_reg;
    logic [3:0] index_reg;

    logic [3:0]  rd_addr;
    logic [7:0]  entry;
    logic [7:0]  inc_sum;
    logic [15:0] inc_prod;
    logic [4:0]  inc_q;
    logic [7:0]  inc_r;
    logic [7:0]  inc_byte;
    logic [7:0]  month_dec;
    logic [7:0]  year_dec;
    logic        leap;
    logic [7:0]  month_days;

    logic        store_we;
    logic [3:0]  store_addr;
    logic [7:0]  store_data;
    logic        ctl_we;
    logic [1:0]  phase_next;
    logic [3:0]  index_next;
    logic [7:0]  result_next;
    logic        carry;

    // One read port serves both the window and the tick walk.
    assign rd_addr = cmd.tick_en ? {1'b0, cmd.field} : index_reg;
    assign entry   = clock_store_reg[rd_addr];

    // BCD increment; the divide by ten is a reciprocal multiply, exact
    // for every sum this byte can produce.
    assign inc_sum  = nirtc_pkg::bcd_decode(entry) + 8'd1;
    assign inc_prod = {8'h00, inc_sum} * 16'd205;
    assign inc_q    = inc_prod[15:11];
    assign inc_r    = inc_sum - (({3'b000, inc_q} << 3) + ({3'b000, inc_q} << 1));
    assign inc_byte = {inc_q[3:0], inc_r[3:0]};

    // 1900 + year is a leap year exactly when the year is a nonzero
    // multiple of four, over the whole range that two digits can decode to.
    assign month_dec  = nirtc_pkg::bcd_decode(clock_store_reg[nirtc_pkg::REG_MONTHS]);
    assign year_dec   = nirtc_pkg::bcd_decode(clock_store_reg[nirtc_pkg::REG_YEARS]);
    assign leap       = (year_dec[1:0] == 2'b00) && (year_dec != 8'd0);
    assign month_days = nirtc_pkg::days_in_month(month_dec, leap);

    always_comb begin
        store_we    = 1'b0;
        store_addr  = rd_addr;
        store_data  = entry;
        ctl_we      = 1'b0;
        phase_next  = phase_reg;
        index_next  = index_reg;
        result_next = 8'h00;
        carry       = 1'b0;

        if (cmd.tick_en) begin
            store_we = 1'b1;
            case (cmd.field)
                nirtc_pkg::FIELD_SECONDS, nirtc_pkg::FIELD_MINUTES: begin
                    carry      = (inc_byte >= 8'h60);
                    store_data = carry ? 8'h00 : inc_byte;
                end
                nirtc_pkg::FIELD_HOURS: begin
                    carry      = (inc_byte >= 8'h24);
                    store_data = carry ? 8'h00 : inc_byte;
                end
                nirtc_pkg::FIELD_DAYS: begin
                    carry      = (nirtc_pkg::bcd_decode(inc_byte) > month_days);
                    store_data = carry ? 8'h01 : inc_byte;
                end
                nirtc_pkg::FIELD_MONTHS: begin
                    carry      = (inc_byte > 8'h12);
                    store_data = carry ? 8'h01 : inc_byte;
                end
                nirtc_pkg::FIELD_YEARS: begin
                    store_data = (inc_sum >= 8'd100) ? 8'h00 : inc_byte;
                end
                default: begin
                    store_we = 1'b0;
                end
            endcase
        end else if (cmd.bus_exec) begin
            if (mode_reg == nirtc_pkg::MODE_WRITE) begin
                if (!offset_reg[3]) begin
                    ctl_we = 1'b1;
                end else if (offset_reg == nirtc_pkg::WINDOW_OFFSET) begin
                    case (phase_reg)
                        nirtc_pkg::PHASE_INDEX: begin
                            index_next = wdata_reg[3:0];
                            phase_next = nirtc_pkg::PHASE_HIGH;
                        end
                        nirtc_pkg::PHASE_HIGH: begin
                            store_we   = 1'b1;
                            store_data = {wdata_reg[3:0], entry[3:0]};
                            phase_next = nirtc_pkg::PHASE_LOW;
                        end
                        nirtc_pkg::PHASE_LOW: begin
                            store_we   = 1'b1;
                            store_data = {entry[7:4], wdata_reg[3:0]};
                            phase_next = nirtc_pkg::PHASE_INDEX;
                        end
                        default: begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
            end else if (mode_reg == nirtc_pkg::MODE_READ) begin
                if (!offset_reg[3]) begin
                    // The lower four byte registers are write-only.
                    result_next = offset_reg[2] ? control_bytes_reg[offset_reg[2:0]] : 8'h00;
                end else if (offset_reg == nirtc_pkg::WINDOW_OFFSET) begin
                    case (phase_reg)
                        nirtc_pkg::PHASE_HIGH: begin
                            result_next = {4'h0, entry[7:4]};
                            phase_next  = nirtc_pkg::PHASE_LOW;
                        end
                        nirtc_pkg::PHASE_LOW: begin
                            result_next = {4'h0, entry[3:0]};
                            phase_next  = nirtc_pkg::PHASE_INDEX;
                        end
                        default: begin
                            result_next = 8'h00;
                        end
                    endcase
                end else begin
                    result_next = 8'hFF;
                end
            end
        end
    end

    assign status.is_tick      = (mode_reg == nirtc_pkg::MODE_TICK);
    assign status.tick_enabled = clock_store_reg[nirtc_pkg::REG_CONTROL][0];
    assign status.carry        = carry;

    assign m_tdata = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) begin
                control_bytes_reg[i] <= 8'h00;
            end
            for (int i = 0; i < 16; i++) begin
                clock_store_reg[i] <= nirtc_pkg::CLOCK_RESET_IMAGE[i];
            end
            phase_reg <= nirtc_pkg::PHASE_INDEX;
            index_reg <= 4'd0;
        end else begin
            if (ctl_we) begin
                control_bytes_reg[offset_reg[2:0]] <= wdata_reg;
            end
            if (store_we) begin
                clock_store_reg[store_addr] <= store_data;
            end
            phase_reg <= phase_next;
            index_reg <= index_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg   <= s_tuser;
            offset_reg <= s_tdata[3:0];
            wdata_reg  <= s_tdata[11:4];
        end
        if (cmd.bus_exec) begin
            result_reg <= result_next;
        end
        if (cmd.out_load) begin
            m_data_reg <= result_reg;
        end
    end

endmodule
